>>> hw/rtl/salc_pkg.sv
// Shared types and codes of the set-associative LRU cache tag store.
package salc_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EV,
        S_DONE
    } t_state;

    localparam logic [1:0] CFG_WAYS_LOG2      = 2'd0;
    localparam logic [1:0] CFG_WRITE_ALLOCATE = 2'd1;
    localparam logic [1:0] CFG_PREFETCH_MODE  = 2'd2;

    localparam logic [1:0] PF_NONE   = 2'd0;
    localparam logic [1:0] PF_ALWAYS = 2'd1;
    localparam logic [1:0] PF_MISS   = 2'd2;

    localparam int CFG_DATA_W  = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W     = 32;

endpackage

>>> hw/rtl/salc_tag_ram.sv
// Single-write, single-read tag RAM with registered read data.
module salc_tag_ram #(
    parameter int DEPTH_LOG2 = 9,
    parameter int WIDTH      = 60
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DEPTH_LOG2-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [DEPTH_LOG2-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] mem [2**DEPTH_LOG2];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/set_assoc_lru_cache_tags_core.sv
// Tag store of a set-associative cache with LRU fill and optional next-line prefetch.
// One demand word is taken at a time. Each lookup walks the ways of its set through
// the single tag RAM, a read state (S_RD) then a compare-and-update state (S_EV) per
// way examined, ending at the first hit or after all ways; a prefetch lookup repeats
// that walk for the next line. After reset the RAM is swept clear, one entry a cycle,
// over its 2^floor(log2 LINES) entries (512 by default); no input word is taken during
// that sweep, configuration writes are. A new input word is taken while the previous
// result still waits on a stalled output.
module set_assoc_lru_cache_tags_core #(
    parameter int LINES       = 512,
    parameter int LINE_BYTES  = 32,
    parameter int ADDR_WIDTH  = 32,
    parameter int MAX_WAYS    = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ADDR_WIDTH-1:0]          i_address,
    input  logic                           i_is_store,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [salc_pkg::COUNT_W-1:0]   o_hit_count,
    output logic [salc_pkg::COUNT_W-1:0]   o_access_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [salc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LL     = $clog2(LINES + 1) - 1;
    localparam int OFF    = $clog2(LINE_BYTES + 1) - 1;
    localparam int MWL    = $clog2(MAX_WAYS + 1) - 1;
    localparam int WL_MAX = (MWL < LL) ? MWL : LL;
    localparam int WB     = (WL_MAX > 0) ? WL_MAX : 1;
    localparam int TAGW   = ADDR_WIDTH - OFF;
    localparam int SBW    = $clog2(LL + 1);
    localparam int WORD_W = 1 + TAGW + STAMP_WIDTH;
    localparam int CW     = salc_pkg::COUNT_W;

    salc_pkg::t_state r_state, n_state;

    logic [2:0]             r_ways_log2;
    logic                   r_write_alloc;
    logic [1:0]             r_pf_mode;

    logic [ADDR_WIDTH-1:0]  r_addr, n_addr;
    logic                   r_may_fill, n_may_fill;
    logic                   r_is_pf, n_is_pf;
    logic                   r_dem_hit, n_dem_hit;
    logic [WB-1:0]          r_way, n_way;
    logic [WB-1:0]          r_victim, n_victim;
    logic                   r_have_inv, n_have_inv;
    logic                   r_have_best, n_have_best;
    logic [STAMP_WIDTH-1:0] r_best, n_best;
    logic [STAMP_WIDTH-1:0] r_stamp, n_stamp;
    logic [CW-1:0]          r_hits, n_hits;
    logic [CW-1:0]          r_accesses, n_accesses;
    logic [LL-1:0]          r_clr, n_clr;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_hit;
    logic [CW-1:0]          r_out_hits;
    logic [CW-1:0]          r_out_acc;
    logic                   out_load;

    logic [2:0]             wl;
    logic [SBW-1:0]         set_bits;
    logic [TAGW-1:0]        line_idx;
    logic [TAGW-1:0]        tag;
    logic [LL-1:0]          set_mask;
    logic [LL-1:0]          set_idx;
    logic [WB-1:0]          last_way;

    logic                   we;
    logic [LL-1:0]          waddr;
    logic [WORD_W-1:0]      wdata;
    logic [LL-1:0]          raddr;
    logic [WORD_W-1:0]      rdata;

    logic                   d_valid;
    logic [TAGW-1:0]        d_tag;
    logic [STAMP_WIDTH-1:0] d_stamp;
    logic                   d_match;
    logic                   do_pf;

    function automatic logic [LL-1:0] entry_of(input logic [WB-1:0] way,
                                               input logic [SBW-1:0] sb,
                                               input logic [LL-1:0] set);
        logic [LL-1:0] w_ext;
        w_ext = LL'(way);
        return (w_ext << sb) | set;
    endfunction

    // Clamp associativity to what the RAM and MAX_WAYS allow.
    assign wl       = (r_ways_log2 > 3'(WL_MAX)) ? 3'(WL_MAX) : r_ways_log2;
    assign set_bits = SBW'(LL) - SBW'(wl);
    assign line_idx = r_addr[ADDR_WIDTH-1:OFF];
    assign tag      = line_idx >> set_bits;
    assign set_mask = ~({LL{1'b1}} << set_bits);
    assign set_idx  = line_idx[LL-1:0] & set_mask;
    assign last_way = WB'((1 << wl) - 1);

    assign d_valid = rdata[WORD_W-1];
    assign d_tag   = rdata[WORD_W-2 -: TAGW];
    assign d_stamp = rdata[STAMP_WIDTH-1:0];
    assign d_match = d_valid && (d_tag == tag);
    assign do_pf   = (r_pf_mode == salc_pkg::PF_ALWAYS) ||
                     ((r_pf_mode == salc_pkg::PF_MISS) && !d_match);

    assign raddr    = entry_of(r_way, set_bits, set_idx);
    assign out_load = (r_state == salc_pkg::S_DONE) && (!r_out_valid || !i_stall);

    salc_tag_ram #(
        .DEPTH_LOG2 (LL),
        .WIDTH      (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_may_fill  = r_may_fill;
        n_is_pf     = r_is_pf;
        n_dem_hit   = r_dem_hit;
        n_way       = r_way;
        n_victim    = r_victim;
        n_have_inv  = r_have_inv;
        n_have_best = r_have_best;
        n_best      = r_best;
        n_stamp     = r_stamp;
        n_hits      = r_hits;
        n_accesses  = r_accesses;
        n_clr       = r_clr;
        we          = 1'b0;
        waddr       = r_clr;
        wdata       = '0;
        case (r_state)
            salc_pkg::S_CLEAR: begin
                we    = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == {LL{1'b1}}) begin
                    n_state = salc_pkg::S_IDLE;
                end
            end
            salc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_addr      = i_address;
                    n_may_fill  = !i_is_store || r_write_alloc;
                    n_is_pf     = 1'b0;
                    n_way       = '0;
                    n_have_inv  = 1'b0;
                    n_have_best = 1'b0;
                    n_stamp     = r_stamp + 1'b1;
                    n_accesses  = r_accesses + 1'b1;
                    n_state     = salc_pkg::S_RD;
                end
            end
            salc_pkg::S_RD: begin
                n_state = salc_pkg::S_EV;
            end
            salc_pkg::S_EV: begin
                if (!d_match) begin
                    if (!d_valid) begin
                        if (!r_have_inv) begin
                            n_have_inv = 1'b1;
                            n_victim   = r_way;
                        end
                    end else if (!r_have_inv && (!r_have_best || d_stamp < r_best)) begin
                        n_have_best = 1'b1;
                        n_best      = d_stamp;
                        n_victim    = r_way;
                    end
                end
                if (d_match || r_way == last_way) begin
                    if (d_match) begin
                        // refresh the stamp of the hit line
                        we    = 1'b1;
                        waddr = raddr;
                        wdata = {1'b1, d_tag, r_stamp};
                    end else if (r_may_fill) begin
                        we    = 1'b1;
                        waddr = entry_of(n_victim, set_bits, set_idx);
                        wdata = {1'b1, tag, r_stamp};
                    end
                    if (!r_is_pf) begin
                        n_dem_hit = d_match;
                        if (d_match) begin
                            n_hits = r_hits + 1'b1;
                        end
                    end
                    if (!r_is_pf && do_pf) begin
                        n_addr      = r_addr + ADDR_WIDTH'(LINE_BYTES);
                        n_may_fill  = 1'b1;
                        n_is_pf     = 1'b1;
                        n_way       = '0;
                        n_have_inv  = 1'b0;
                        n_have_best = 1'b0;
                        n_stamp     = r_stamp + 1'b1;
                        n_state     = salc_pkg::S_RD;
                    end else begin
                        n_state = salc_pkg::S_DONE;
                    end
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = salc_pkg::S_RD;
                end
            end
            salc_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = salc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = salc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= salc_pkg::S_CLEAR;
            r_clr       <= '0;
            r_stamp     <= '0;
            r_hits      <= '0;
            r_accesses  <= '0;
            r_is_pf     <= 1'b0;
            r_way       <= '0;
            r_have_inv  <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_stamp     <= n_stamp;
            r_hits      <= n_hits;
            r_accesses  <= n_accesses;
            r_is_pf     <= n_is_pf;
            r_way       <= n_way;
            r_have_inv  <= n_have_inv;
            r_have_best <= n_have_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_may_fill <= n_may_fill;
        r_dem_hit  <= n_dem_hit;
        r_victim   <= n_victim;
        r_best     <= n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_log2   <= 3'd1;
            r_write_alloc <= 1'b1;
            r_pf_mode     <= salc_pkg::PF_NONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                salc_pkg::CFG_WAYS_LOG2:      r_ways_log2   <= i_cfg_data[2:0];
                salc_pkg::CFG_WRITE_ALLOCATE: r_write_alloc <= i_cfg_data[0];
                salc_pkg::CFG_PREFETCH_MODE:  r_pf_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Output word register: hold while stalled, drop once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit  <= r_dem_hit;
            r_out_hits <= r_hits;
            r_out_acc  <= r_accesses;
        end
    end

    assign o_stall        = (r_state != salc_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_hit_count    = r_out_hits;
    assign o_access_count = r_out_acc;

`ifndef SYNTHESIS
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == salc_pkg::S_CLEAR || r_state == salc_pkg::S_EV))
        else $error("tag RAM written outside clear or compare");

    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == salc_pkg::S_EV) |-> (r_way <= last_way))
        else $error("way walk past last way");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && o_access_count == $past(r_accesses)
                      && o_hit_count == $past(r_hits)))
        else $error("result word not loaded");

    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hits != $past(r_hits)) |-> ($past(r_state) == salc_pkg::S_EV && !$past(r_is_pf)))
        else $error("hit total moved outside a demand lookup");
`endif

endmodule
